// ===== rtl/core/scoped_definition_save_stack_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the scoped definition save stack
// Shared property wrappers used by the checker.
// ----------------------------------------------------------------------------
`ifndef SCOPED_DEFINITION_SAVE_STACK_DEFINES_SVH
`define SCOPED_DEFINITION_SAVE_STACK_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define SDS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled in reset.
`define SDS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/core/sds_pkg.sv =====
// ----------------------------------------------------------------------------
// sds_pkg
// Types and codes shared by the save stack and its checker.
// ----------------------------------------------------------------------------
package sds_pkg;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_NOTE,
      ST_DONE,
      ST_POP_RD,
      ST_POP_TAB,
      ST_POP_WR
   } state_type;

   localparam logic [2:0] OP_OPEN  = 3'd0;
   localparam logic [2:0] OP_LDEF  = 3'd1;
   localparam logic [2:0] OP_LWORD = 3'd2;
   localparam logic [2:0] OP_GDEF  = 3'd3;
   localparam logic [2:0] OP_GWORD = 3'd4;
   localparam logic [2:0] OP_TOKEN = 3'd5;
   localparam logic [2:0] OP_CLOSE = 3'd6;
   localparam logic [2:0] OP_READ  = 3'd7;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_FULL  = 2'd1;
   localparam logic [1:0] STAT_LEVEL = 2'd2;
   localparam logic [1:0] STAT_OUTER = 2'd3;

   localparam logic [1:0] RK_DONE     = 2'd0;
   localparam logic [1:0] RK_REINSERT = 2'd1;
   localparam logic [1:0] RK_RELEASE  = 2'd2;
   localparam logic [1:0] RK_READ     = 2'd3;

   localparam logic [1:0] REC_BOUNDARY = 2'd0;
   localparam logic [1:0] REC_RESTORE  = 2'd1;
   localparam logic [1:0] REC_TOKEN    = 2'd2;

   localparam logic [9:0] WRS_RESET  = 10'd512;
   localparam logic [5:0] NOTE_LIMIT = 6'd63;

   localparam int REQ_TDATA_W = 64;
   localparam int RSP_TDATA_W = 72;
   localparam int RSP_CUR_LEVEL_LSB = 58;

endpackage

// ===== rtl/core/scoped_definition_save_stack.sv =====
// ----------------------------------------------------------------------------
// scoped_definition_save_stack
// Scoped definition table with an undo stack for grouped definitions.
// ----------------------------------------------------------------------------
// Usage: one operation enters on the req_ stream (opcode in tuser, entry
// fields in tdata); its results leave on the rsp_ stream, zero or more
// release/reinsert notices followed by one final transaction marked tlast.
// A read answers with a single read-data transaction.
// Timing: the definition table and the undo stack are synchronous memories
// with registered read data. An operation steps through accept, table
// read-modify-write and final result, plus a release notice when it emits one.
// A close pops records in a stack read/table read-modify-write loop (a restore
// adds a table write step) and adds a notice step per notice.
// Reset: the table is swept to kind 0, value 0, level 1, one entry a cycle,
// over all TABLE_DEPTH entries, during which req_tready stays low. csr_wr_en
// writes word_region_start whenever reset is low, also during the sweep.
// Stall: results sit in an output register; while it holds a result and
// rsp_tready is low, the sequencer holds before loading its next result. The
// final transaction may still wait there while the next operation is accepted.
// ----------------------------------------------------------------------------
module scoped_definition_save_stack #(
   parameter int TABLE_DEPTH = 1024,
   parameter int STACK_DEPTH = 64,
   parameter int MAX_LEVEL   = 255
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // entry_index[9:0], entry_kind[17:10], entry_value[49:18], group_code[57:50]
   input  logic [63:0] req_tdata,
   // opcode[2:0]
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status[1:0], out_kind[9:2], out_value[41:10], out_level[49:42],
   // current_group[57:50], current_level[65:58]
   output logic [71:0] rsp_tdata,
   // result_kind[1:0]
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic [9:0]  csr_wr_data
);

   localparam int IDX_W      = $clog2(TABLE_DEPTH);
   localparam int SA_W       = $clog2(STACK_DEPTH);
   localparam int ST_W       = SA_W + 1;
   localparam int CMP_W      = 10 + IDX_W;
   localparam int R_IDX_LSB  = 10;
   localparam int R_KIND_LSB = 10 + IDX_W;
   localparam int R_VAL_LSB  = 18 + IDX_W;
   localparam int REC_W      = 50 + IDX_W;

   // Memories: table entry = {value, kind, level}
   logic [47:0]      tab_mem [TABLE_DEPTH];
   logic [REC_W-1:0] stk_mem [STACK_DEPTH];
   logic [47:0]      tab_q;
   logic [REC_W-1:0] stk_q;
   logic [IDX_W-1:0] tab_ra, tab_wa;
   logic [47:0]      tab_wd;
   logic             tab_we;
   logic [SA_W-1:0]  stk_ra, stk_wa;
   logic [REC_W-1:0] stk_wd;
   logic             stk_we;

   // Control and state registers
   sds_pkg::state_type state_ff, state_in;
   logic [IDX_W-1:0] clr_ff, clr_in;
   logic [ST_W-1:0]  top_ff, top_in;
   logic [SA_W-1:0]  bnd_ff, bnd_in;
   logic [7:0]       nest_ff, nest_in;
   logic [7:0]       grp_ff, grp_in;
   logic [9:0]       wrs_ff;
   logic [5:0]       cnt_ff, cnt_in;
   logic [1:0]       status_ff, status_in;

   // Latched operation
   logic [2:0]       op_ff, op_in;
   logic [IDX_W-1:0] p_ff, p_in;
   logic [7:0]       kind_ff, kind_in;
   logic [31:0]      value_ff, value_in;
   logic [7:0]       code_ff, code_in;
   logic [REC_W-1:0] rec_ff, rec_in;

   // Pending notice
   logic [1:0]  note_rk_ff, note_rk_in;
   logic [7:0]  note_kind_ff, note_kind_in;
   logic [31:0] note_value_ff, note_value_in;
   logic [7:0]  note_level_ff, note_level_in;
   logic        note_last_ff, note_last_in;

   // Output register
   logic        rsp_tvalid_ff, rsp_tvalid_in;
   logic [71:0] rsp_tdata_ff, rsp_tdata_in;
   logic [1:0]  rsp_tuser_ff, rsp_tuser_in;
   logic        rsp_tlast_ff, rsp_tlast_in;
   logic        out_load;

   // Decoded fields
   logic [CMP_W-1:0] req_index_x;
   logic [IDX_W-1:0] p_req;
   logic [7:0]       tab_lvl, tab_kind;
   logic [31:0]      tab_val;
   logic [1:0]       srec_type, rec_type;
   logic [7:0]       srec_level, rec_level, rec_kind;
   logic [IDX_W-1:0] srec_idx, rec_idx;
   logic [31:0]      srec_val, rec_val;
   logic             full, accept, slot_free, note_ok, rec_in_defs;
   logic             exec_note, exec_pop;

   assign req_index_x = CMP_W'(req_tdata[9:0]);
   assign p_req       = req_index_x[IDX_W-1:0];
   assign tab_lvl     = tab_q[7:0];
   assign tab_kind    = tab_q[15:8];
   assign tab_val     = tab_q[47:16];
   assign srec_type   = stk_q[1:0];
   assign srec_level  = stk_q[9:2];
   assign srec_idx    = stk_q[R_IDX_LSB +: IDX_W];
   assign srec_val    = stk_q[R_VAL_LSB +: 32];
   assign rec_type    = rec_ff[1:0];
   assign rec_level   = rec_ff[9:2];
   assign rec_idx     = rec_ff[R_IDX_LSB +: IDX_W];
   assign rec_kind    = rec_ff[R_KIND_LSB +: 8];
   assign rec_val     = rec_ff[R_VAL_LSB +: 32];

   assign full        = (top_ff == ST_W'(STACK_DEPTH));
   assign req_tready  = (state_ff == sds_pkg::ST_IDLE);
   assign accept      = req_tvalid && req_tready;
   assign slot_free   = !rsp_tvalid_ff || rsp_tready;
   assign note_ok     = (cnt_ff != sds_pkg::NOTE_LIMIT);
   assign rec_in_defs = (CMP_W'(rec_idx) < CMP_W'(wrs_ff));

   // Notice needed straight out of the execute step
   assign exec_note = (op_ff == sds_pkg::OP_READ) || (op_ff == sds_pkg::OP_GDEF) ||
                      ((op_ff == sds_pkg::OP_LDEF) && (tab_lvl == nest_ff));
   assign exec_pop  = (op_ff == sds_pkg::OP_CLOSE) && (nest_ff > 8'd1);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sds_pkg::ST_CLEAR: begin
            if (clr_ff == IDX_W'(TABLE_DEPTH - 1)) state_in = sds_pkg::ST_IDLE;
         end
         sds_pkg::ST_IDLE: begin
            if (accept) state_in = sds_pkg::ST_EXEC;
         end
         sds_pkg::ST_EXEC: begin
            if (exec_note)     state_in = sds_pkg::ST_NOTE;
            else if (exec_pop) state_in = sds_pkg::ST_POP_RD;
            else               state_in = sds_pkg::ST_DONE;
         end
         sds_pkg::ST_NOTE: begin
            if (slot_free) begin
               if (note_last_ff)                   state_in = sds_pkg::ST_IDLE;
               else if (op_ff == sds_pkg::OP_CLOSE) state_in = sds_pkg::ST_POP_RD;
               else                                 state_in = sds_pkg::ST_DONE;
            end
         end
         sds_pkg::ST_DONE: begin
            if (slot_free) state_in = sds_pkg::ST_IDLE;
         end
         sds_pkg::ST_POP_RD: begin
            if (top_ff == '0) state_in = sds_pkg::ST_DONE;
            else              state_in = sds_pkg::ST_POP_TAB;
         end
         sds_pkg::ST_POP_TAB: begin
            case (srec_type)
               sds_pkg::REC_BOUNDARY: state_in = sds_pkg::ST_DONE;
               sds_pkg::REC_TOKEN:    state_in = note_ok ? sds_pkg::ST_NOTE
                                                         : sds_pkg::ST_POP_RD;
               default:               state_in = sds_pkg::ST_POP_WR;
            endcase
         end
         sds_pkg::ST_POP_WR: begin
            if (rec_in_defs && note_ok) state_in = sds_pkg::ST_NOTE;
            else                        state_in = sds_pkg::ST_POP_RD;
         end
         default: state_in = sds_pkg::ST_CLEAR;
      endcase
   end

   // Datapath, memory control and result loading
   always_comb begin
      clr_in        = clr_ff;
      top_in        = top_ff;
      bnd_in        = bnd_ff;
      nest_in       = nest_ff;
      grp_in        = grp_ff;
      cnt_in        = cnt_ff;
      status_in     = status_ff;
      op_in         = op_ff;
      p_in          = p_ff;
      kind_in       = kind_ff;
      value_in      = value_ff;
      code_in       = code_ff;
      rec_in        = rec_ff;
      note_rk_in    = note_rk_ff;
      note_kind_in  = note_kind_ff;
      note_value_in = note_value_ff;
      note_level_in = note_level_ff;
      note_last_in  = note_last_ff;
      tab_ra        = p_ff;
      tab_we        = 1'b0;
      tab_wa        = p_ff;
      tab_wd        = {value_ff, kind_ff, nest_ff};
      stk_ra        = bnd_ff;
      stk_we        = 1'b0;
      stk_wa        = top_ff[SA_W-1:0];
      stk_wd        = '0;
      out_load      = 1'b0;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      rsp_tlast_in  = rsp_tlast_ff;

      case (state_ff)
         sds_pkg::ST_CLEAR: begin
            tab_we = 1'b1;
            tab_wa = clr_ff;
            tab_wd = {32'd0, 8'd0, 8'd1};
            clr_in = clr_ff + 1'b1;
         end
         sds_pkg::ST_IDLE: begin
            // Read the entry and the current boundary record up front
            tab_ra = p_req;
            stk_ra = bnd_ff;
            if (accept) begin
               op_in     = req_tuser;
               p_in      = p_req;
               kind_in   = req_tdata[17:10];
               value_in  = req_tdata[49:18];
               code_in   = req_tdata[57:50];
               status_in = sds_pkg::STAT_OK;
               cnt_in    = '0;
            end
         end
         sds_pkg::ST_EXEC: begin
            // Default save record: restore of the old entry
            stk_wd = {value_ff[31:0] & 32'd0, 8'd0, {IDX_W{1'b0}}, 8'd0, 2'd0};
            stk_wd[1:0]                = sds_pkg::REC_RESTORE;
            stk_wd[9:2]                = tab_lvl;
            stk_wd[R_IDX_LSB +: IDX_W] = p_ff;
            stk_wd[R_KIND_LSB +: 8]    = tab_kind;
            stk_wd[R_VAL_LSB +: 32]    = tab_val;
            note_rk_in    = sds_pkg::RK_RELEASE;
            note_kind_in  = tab_kind;
            note_value_in = tab_val;
            note_level_in = 8'd0;
            note_last_in  = 1'b0;
            case (op_ff)
               sds_pkg::OP_OPEN: begin
                  if (full) begin
                     status_in = sds_pkg::STAT_FULL;
                  end else if (nest_ff >= 8'(MAX_LEVEL)) begin
                     status_in = sds_pkg::STAT_LEVEL;
                  end else begin
                     stk_we                  = 1'b1;
                     stk_wd                  = '0;
                     stk_wd[1:0]             = sds_pkg::REC_BOUNDARY;
                     stk_wd[9:2]             = grp_ff;
                     stk_wd[R_VAL_LSB +: 32] = 32'(bnd_ff);
                     bnd_in                  = top_ff[SA_W-1:0];
                     top_in                  = top_ff + 1'b1;
                     nest_in                 = nest_ff + 8'd1;
                     grp_in                  = code_ff;
                  end
               end
               sds_pkg::OP_LDEF: begin
                  if (tab_lvl == nest_ff) begin
                     tab_we = 1'b1;
                  end else if (nest_ff > 8'd1) begin
                     if (full) begin
                        status_in = sds_pkg::STAT_FULL;
                     end else begin
                        stk_we = 1'b1;
                        top_in = top_ff + 1'b1;
                        tab_we = 1'b1;
                     end
                  end else begin
                     tab_we = 1'b1;
                  end
               end
               sds_pkg::OP_LWORD: begin
                  if (tab_lvl != nest_ff) begin
                     if (full) begin
                        status_in = sds_pkg::STAT_FULL;
                     end else begin
                        stk_we = 1'b1;
                        top_in = top_ff + 1'b1;
                        tab_we = 1'b1;
                        tab_wd = {value_ff, tab_kind, nest_ff};
                     end
                  end else begin
                     tab_we = 1'b1;
                     tab_wd = {value_ff, tab_kind, tab_lvl};
                  end
               end
               sds_pkg::OP_GDEF: begin
                  tab_we = 1'b1;
                  tab_wd = {value_ff, kind_ff, 8'd1};
               end
               sds_pkg::OP_GWORD: begin
                  tab_we = 1'b1;
                  tab_wd = {value_ff, tab_kind, 8'd1};
               end
               sds_pkg::OP_TOKEN: begin
                  if (nest_ff > 8'd1) begin
                     if (full) begin
                        status_in = sds_pkg::STAT_FULL;
                     end else begin
                        stk_we                  = 1'b1;
                        stk_wd                  = '0;
                        stk_wd[1:0]             = sds_pkg::REC_TOKEN;
                        stk_wd[R_VAL_LSB +: 32] = value_ff;
                        top_in                  = top_ff + 1'b1;
                     end
                  end
               end
               sds_pkg::OP_CLOSE: begin
                  // Final level and group are known now: the boundary
                  // record of this group was read at accept
                  if (nest_ff <= 8'd1) begin
                     status_in = sds_pkg::STAT_OUTER;
                  end else begin
                     nest_in = nest_ff - 8'd1;
                     grp_in  = srec_level;
                  end
               end
               default: begin
                  note_rk_in    = sds_pkg::RK_READ;
                  note_level_in = tab_lvl;
                  note_last_in  = 1'b1;
               end
            endcase
         end
         sds_pkg::ST_NOTE: begin
            if (slot_free) begin
               out_load     = 1'b1;
               rsp_tdata_in = {6'd0, nest_ff, grp_ff, note_level_ff, note_value_ff,
                               note_kind_ff, status_ff};
               rsp_tuser_in = note_rk_ff;
               rsp_tlast_in = note_last_ff;
            end
         end
         sds_pkg::ST_DONE: begin
            if (slot_free) begin
               out_load     = 1'b1;
               rsp_tdata_in = {6'd0, nest_ff, grp_ff, 8'd0, 32'd0, 8'd0, status_ff};
               rsp_tuser_in = sds_pkg::RK_DONE;
               rsp_tlast_in = 1'b1;
            end
         end
         sds_pkg::ST_POP_RD: begin
            if (top_ff == '0) begin
               grp_in = 8'd0;
               bnd_in = '0;
            end else begin
               top_in = top_ff - 1'b1;
               stk_ra = top_in[SA_W-1:0];
            end
         end
         sds_pkg::ST_POP_TAB: begin
            tab_ra = srec_idx;
            rec_in = stk_q;
            case (srec_type)
               sds_pkg::REC_BOUNDARY: begin
                  grp_in = srec_level;
                  bnd_in = srec_val[SA_W-1:0];
               end
               sds_pkg::REC_TOKEN: begin
                  note_rk_in    = sds_pkg::RK_REINSERT;
                  note_kind_in  = 8'd0;
                  note_value_in = srec_val;
                  note_level_in = 8'd0;
                  note_last_in  = 1'b0;
                  if (note_ok) cnt_in = cnt_ff + 6'd1;
               end
               default: begin
               end
            endcase
         end
         sds_pkg::ST_POP_WR: begin
            tab_wa        = rec_idx;
            note_rk_in    = sds_pkg::RK_RELEASE;
            note_level_in = 8'd0;
            note_last_in  = 1'b0;
            if (rec_in_defs) begin
               if (tab_lvl == 8'd1) begin
                  // Entry went global meanwhile: drop the saved copy
                  note_kind_in  = rec_kind;
                  note_value_in = rec_val;
               end else begin
                  note_kind_in  = tab_kind;
                  note_value_in = tab_val;
                  tab_we        = 1'b1;
                  tab_wd        = {rec_val, rec_kind, rec_level};
               end
               if (note_ok) cnt_in = cnt_ff + 6'd1;
            end else if (tab_lvl != 8'd1) begin
               tab_we = 1'b1;
               tab_wd = {rec_val, tab_kind, rec_level};
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_tvalid_in = out_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_tvalid_ff);

   // Memories
   always_ff @(posedge clock) begin
      if (tab_we) tab_mem[tab_wa] <= tab_wd;
      tab_q <= tab_mem[tab_ra];
   end

   always_ff @(posedge clock) begin
      if (stk_we) stk_mem[stk_wa] <= stk_wd;
      stk_q <= stk_mem[stk_ra];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= sds_pkg::ST_CLEAR;
         clr_ff        <= '0;
         top_ff        <= '0;
         bnd_ff        <= '0;
         nest_ff       <= 8'd1;
         grp_ff        <= 8'd0;
         wrs_ff        <= sds_pkg::WRS_RESET;
         cnt_ff        <= '0;
         status_ff     <= sds_pkg::STAT_OK;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         top_ff        <= top_in;
         bnd_ff        <= bnd_in;
         nest_ff       <= nest_in;
         grp_ff        <= grp_in;
         cnt_ff        <= cnt_in;
         status_ff     <= status_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (csr_wr_en) wrs_ff <= csr_wr_data;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      p_ff          <= p_in;
      kind_ff       <= kind_in;
      value_ff      <= value_in;
      code_ff       <= code_in;
      rec_ff        <= rec_in;
      note_rk_ff    <= note_rk_in;
      note_kind_ff  <= note_kind_in;
      note_value_ff <= note_value_in;
      note_level_ff <= note_level_in;
      note_last_ff  <= note_last_in;
      rsp_tdata_ff  <= rsp_tdata_in;
      rsp_tuser_ff  <= rsp_tuser_in;
      rsp_tlast_ff  <= rsp_tlast_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tlast  = rsp_tlast_ff;

endmodule

// ===== rtl/core/sds_checker.sv =====
// ----------------------------------------------------------------------------
// sds_checker
// Port-level checks on the save stack result stream.
// ----------------------------------------------------------------------------
`include "scoped_definition_save_stack_defines.svh"

module sds_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);

   logic notice;
   assign notice = (rsp_tuser == sds_pkg::RK_REINSERT) || (rsp_tuser == sds_pkg::RK_RELEASE);

   // Hold a stalled result
   `SDS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   // Close a read or a finished operation with tlast; notices never end one
   `SDS_ASSERT_NOW(a_final_last, clock, reset, rsp_tvalid && !notice, rsp_tlast)
   `SDS_ASSERT_NOW(a_notice_open, clock, reset, rsp_tvalid && notice, !rsp_tlast)
   // Nesting level never drops below one
   `SDS_ASSERT_NOW(a_level_nonzero, clock, reset, rsp_tvalid, rsp_tdata[sds_pkg::RSP_CUR_LEVEL_LSB +: 8] != 8'd0)
   // Take no new operation while a notice waits
   `SDS_ASSERT_NOW(a_no_overlap, clock, reset, rsp_tvalid && !rsp_tlast, !req_tready)

endmodule

bind scoped_definition_save_stack sds_checker u_sds_checker (.*);
